// ===== hdl/sbc_pkg.sv =====
// Shared constants, types and codes of the swept box collision block.
// Used by every module under hdl; depends on nothing.
`default_nettype none
package sbc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SUM_W     = 35;
	localparam int MAG_W     = 33 + FRAC_BITS;
	localparam int DEN_W     = 32;
	localparam int Q_W       = 33;
	localparam int CMP_W     = DEN_W + Q_W + 1;
	localparam int DIV_LAT   = Q_W + 1;
	localparam int N_DIV     = 4;

	localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] T_MIN = 32'sh80000000;
	localparam logic signed [31:0] T_ONE = 32'(64'd1 << FRAC_BITS);

	localparam logic [1:0] FACE_LEFT  = 2'd0;
	localparam logic [1:0] FACE_RIGHT = 2'd1;
	localparam logic [1:0] FACE_UP    = 2'd2;
	localparam logic [1:0] FACE_DOWN  = 2'd3;

	// Divider slots: near and far bounds of both axes.
	localparam int DIV_NX = 0;
	localparam int DIV_FX = 1;
	localparam int DIV_NY = 2;
	localparam int DIV_FY = 3;

	typedef struct packed {
		logic [MAG_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic             broad;
		logic [N_DIV-1:0] neg;
		logic             dz_x;
		logic             dz_y;
		logic             px_neg;
		logic             py_neg;
	} side_t;

	typedef struct packed {
		logic [Q_W-1:0] quo;
		logic           rem_nz;
		logic           ovf;
	} div_out_t;

endpackage
`default_nettype wire

// ===== hdl/swept_box_collision.sv =====
// Swept box collision: broad phase, four pipelined slab dividers, hit decision.
// From an accepted input beat to its result beat lie two front stages,
// 34 divider stages (overflow check plus 33 quotient bits) and two back stages.
// Throughput is one beat per cycle; the whole pipeline freezes while a result waits.
// arst_n clears all valid bits asynchronously; payload registers are not reset.
// Depends on sbc_pkg, sbc_front, sbc_div and sbc_back.
`default_nettype none
module swept_box_collision (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// From bit 0 up: mover_left[32], mover_top[32], mover_width[31], mover_height[31],
	// path_x[32], path_y[32], target_left[32], target_top[32], target_width[31],
	// target_height[31], then four zero pad bits.
	input  wire logic [319:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// From bit 0 up: hit[1], hit_time[32], normal_face[2], then five zero pad bits.
	output logic [39:0]       m_tdata
);

	// Every stage moves together; a held result holds the whole line, so no
	// beat is lost or repeated while the sink stalls.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic                                   f_valid;
	sbc_pkg::div_in_t  [sbc_pkg::N_DIV-1:0] f_div;
	sbc_pkg::side_t                         f_side;

	sbc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (s_tvalid),
		.mover_left    (s_tdata[31:0]),
		.mover_top     (s_tdata[63:32]),
		.mover_width   (s_tdata[94:64]),
		.mover_height  (s_tdata[125:95]),
		.path_x        (s_tdata[157:126]),
		.path_y        (s_tdata[189:158]),
		.target_left   (s_tdata[221:190]),
		.target_top    (s_tdata[253:222]),
		.target_width  (s_tdata[284:254]),
		.target_height (s_tdata[315:285]),
		.out_valid     (f_valid),
		.div_in        (f_div),
		.side          (f_side)
	);

	// Four dividers run side by side: near and far bound of each axis.
	sbc_pkg::div_out_t [sbc_pkg::N_DIV-1:0] d_res;

	for (genvar k = 0; k < sbc_pkg::N_DIV; k++) begin : g_div
		sbc_div u_div (
			.clk  (clk),
			.adv  (adv),
			.din  (f_div[k]),
			.dout (d_res[k])
		);
	end

	// The sideband and the valid bit walk beside the dividers.
	logic [sbc_pkg::DIV_LAT-1:0] vld_line_s;
	sbc_pkg::side_t              side_line_s [0:sbc_pkg::DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_s <= '0;
		end else if (adv) begin
			vld_line_s <= {vld_line_s[sbc_pkg::DIV_LAT-2:0], f_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_line_s[0] <= f_side;
			for (int i = 1; i < sbc_pkg::DIV_LAT; i++) begin
				side_line_s[i] <= side_line_s[i-1];
			end
		end
	end

	logic               b_hit;
	logic signed [31:0] b_time;
	logic [1:0]         b_face;

	sbc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (vld_line_s[sbc_pkg::DIV_LAT-1]),
		.side        (side_line_s[sbc_pkg::DIV_LAT-1]),
		.dres        (d_res),
		.out_valid   (m_tvalid),
		.hit         (b_hit),
		.hit_time    (b_time),
		.normal_face (b_face)
	);

	assign m_tdata = {5'd0, b_face, b_time, b_hit};

	// A miss must report zero time and the left face.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !b_hit |-> b_time == 0 && b_face == sbc_pkg::FACE_LEFT)
		else $error("miss result carries nonzero fields");

	// The input side is ready exactly when the output slot can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output slot");

	// With no beat leaving the front end, no valid bit enters the divider line.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && adv && !vld_line_s[sbc_pkg::DIV_LAT-1] && !f_valid |=> !vld_line_s[0])
		else $error("valid bit appeared without a beat");

endmodule
`default_nettype wire

// ===== hdl/sbc_front.sv =====
// Front end: box sums, broad phase and slab numerator setup in two stages.
// Depends on sbc_pkg.
`default_nettype none
module sbc_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   adv,
	input  wire logic                                   in_valid,
	input  wire logic signed [31:0]                     mover_left,
	input  wire logic signed [31:0]                     mover_top,
	input  wire logic [30:0]                            mover_width,
	input  wire logic [30:0]                            mover_height,
	input  wire logic signed [31:0]                     path_x,
	input  wire logic signed [31:0]                     path_y,
	input  wire logic signed [31:0]                     target_left,
	input  wire logic signed [31:0]                     target_top,
	input  wire logic [30:0]                            target_width,
	input  wire logic [30:0]                            target_height,
	output logic                                        out_valid,
	output sbc_pkg::div_in_t [sbc_pkg::N_DIV-1:0]       div_in,
	output sbc_pkg::side_t                              side
);

	function automatic logic signed [sbc_pkg::SUM_W-1:0] sx(input logic signed [31:0] v);
		return sbc_pkg::SUM_W'(v);
	endfunction

	function automatic logic signed [sbc_pkg::SUM_W-1:0] zx(input logic [30:0] v);
		return sbc_pkg::SUM_W'(v);
	endfunction

	function automatic sbc_pkg::div_in_t mk_div(input logic signed [sbc_pkg::SUM_W-1:0] n,
			input logic signed [31:0] d);
		sbc_pkg::div_in_t r;
		logic [sbc_pkg::SUM_W-1:0] na;
		na = n[sbc_pkg::SUM_W-1] ? sbc_pkg::SUM_W'(-n) : sbc_pkg::SUM_W'(n);
		r.num = {na[32:0], {sbc_pkg::FRAC_BITS{1'b0}}};
		r.den = d[31] ? sbc_pkg::DEN_W'(-d) : sbc_pkg::DEN_W'(d);
		return r;
	endfunction

	logic                               vld_s1;
	logic signed [sbc_pkg::SUM_W-1:0]   bl_s1, br_s1, bt_s1, bb_s1;
	logic signed [sbc_pkg::SUM_W-1:0]   tl_s1, tr_s1, tt_s1, tb_s1;
	logic signed [sbc_pkg::SUM_W-1:0]   nlx_s1, nhx_s1, nly_s1, nhy_s1;
	logic signed [31:0]                 px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bl_s1  <= sx(mover_left) + (path_x < 0 ? sx(path_x) : '0);
			br_s1  <= sx(mover_left) + zx(mover_width) + (path_x > 0 ? sx(path_x) : '0);
			bt_s1  <= sx(mover_top) + (path_y < 0 ? sx(path_y) : '0);
			bb_s1  <= sx(mover_top) + zx(mover_height) + (path_y > 0 ? sx(path_y) : '0);
			tl_s1  <= sx(target_left);
			tr_s1  <= sx(target_left) + zx(target_width);
			tt_s1  <= sx(target_top);
			tb_s1  <= sx(target_top) + zx(target_height);
			nlx_s1 <= sx(target_left) - sx(mover_left) - zx(mover_width);
			nhx_s1 <= sx(target_left) + zx(target_width) - sx(mover_left);
			nly_s1 <= sx(target_top) - sx(mover_top) - zx(mover_height);
			nhy_s1 <= sx(target_top) + zx(target_height) - sx(mover_top);
			px_s1  <= path_x;
			py_s1  <= path_y;
		end
	end

	logic                               x_neg, y_neg, bx, by;
	logic signed [sbc_pkg::SUM_W-1:0]   nx_num, fx_num, ny_num, fy_num;

	always_comb begin
		x_neg  = px_s1[31];
		y_neg  = py_s1[31];
		nx_num = x_neg ? nhx_s1 : nlx_s1;
		fx_num = x_neg ? nlx_s1 : nhx_s1;
		ny_num = y_neg ? nhy_s1 : nly_s1;
		fy_num = y_neg ? nly_s1 : nhy_s1;
		bx = ((bl_s1 > tl_s1) ? bl_s1 : tl_s1) < ((br_s1 < tr_s1) ? br_s1 : tr_s1);
		by = ((bt_s1 > tt_s1) ? bt_s1 : tt_s1) < ((bb_s1 < tb_s1) ? bb_s1 : tb_s1);
	end

	logic vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	sbc_pkg::div_in_t [sbc_pkg::N_DIV-1:0] div_s2;
	sbc_pkg::side_t                        side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s2[sbc_pkg::DIV_NX] <= mk_div(nx_num, px_s1);
			div_s2[sbc_pkg::DIV_FX] <= mk_div(fx_num, px_s1);
			div_s2[sbc_pkg::DIV_NY] <= mk_div(ny_num, py_s1);
			div_s2[sbc_pkg::DIV_FY] <= mk_div(fy_num, py_s1);
			side_s2.broad                <= bx & by;
			side_s2.neg[sbc_pkg::DIV_NX] <= nx_num[sbc_pkg::SUM_W-1] ^ x_neg;
			side_s2.neg[sbc_pkg::DIV_FX] <= fx_num[sbc_pkg::SUM_W-1] ^ x_neg;
			side_s2.neg[sbc_pkg::DIV_NY] <= ny_num[sbc_pkg::SUM_W-1] ^ y_neg;
			side_s2.neg[sbc_pkg::DIV_FY] <= fy_num[sbc_pkg::SUM_W-1] ^ y_neg;
			side_s2.dz_x                 <= (px_s1 == 0);
			side_s2.dz_y                 <= (py_s1 == 0);
			side_s2.px_neg               <= x_neg;
			side_s2.py_neg               <= y_neg;
		end
	end

	assign out_valid = vld_s2;
	assign div_in    = div_s2;
	assign side      = side_s2;

endmodule
`default_nettype wire

// ===== hdl/sbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on sbc_pkg.
`default_nettype none
module sbc_div (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire sbc_pkg::div_in_t   din,
	output sbc_pkg::div_out_t       dout
);

	typedef struct packed {
		logic [sbc_pkg::CMP_W-1:0] rem;
		logic [sbc_pkg::CMP_W-1:0] den;
		logic [sbc_pkg::Q_W-1:0]   quo;
		logic                      ovf;
	} dstg_t;

	dstg_t stg_s [0:sbc_pkg::Q_W];

	// The first stage flags quotients that do not fit in Q_W bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s[0].rem <= sbc_pkg::CMP_W'(din.num);
			stg_s[0].den <= sbc_pkg::CMP_W'(din.den);
			stg_s[0].quo <= '0;
			stg_s[0].ovf <= sbc_pkg::CMP_W'(din.num) >=
				(sbc_pkg::CMP_W'(din.den) << sbc_pkg::Q_W);
		end
	end

	for (genvar j = 1; j <= sbc_pkg::Q_W; j++) begin : g_stage
		localparam int B = sbc_pkg::Q_W - j;
		logic [sbc_pkg::CMP_W-1:0] sh;
		logic                      take;
		assign sh   = stg_s[j-1].den << B;
		assign take = stg_s[j-1].rem >= sh;
		always_ff @(posedge clk) begin
			if (adv) begin
				stg_s[j].rem <= take ? stg_s[j-1].rem - sh : stg_s[j-1].rem;
				stg_s[j].den <= stg_s[j-1].den;
				stg_s[j].quo <= stg_s[j-1].quo | (sbc_pkg::Q_W'(take) << B);
				stg_s[j].ovf <= stg_s[j-1].ovf;
			end
		end
	end

	assign dout.quo    = stg_s[sbc_pkg::Q_W].quo;
	assign dout.rem_nz = |stg_s[sbc_pkg::Q_W].rem;
	assign dout.ovf    = stg_s[sbc_pkg::Q_W].ovf;

endmodule
`default_nettype wire

// ===== hdl/sbc_back.sv =====
// Back end: rounding and saturation of the slab bounds, then the hit decision.
// Depends on sbc_pkg.
`default_nettype none
module sbc_back (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    adv,
	input  wire logic                                    in_valid,
	input  wire sbc_pkg::side_t                          side,
	input  wire sbc_pkg::div_out_t [sbc_pkg::N_DIV-1:0]  dres,
	output logic                                         out_valid,
	output logic                                         hit,
	output logic signed [31:0]                           hit_time,
	output logic [1:0]                                   normal_face
);

	function automatic logic signed [31:0] fix(input sbc_pkg::div_out_t d,
			input logic neg, input logic up);
		logic                    inc;
		logic [sbc_pkg::Q_W:0]   mag;
		inc = d.rem_nz & (neg ? ~up : up);
		mag = {1'b0, d.quo} + (sbc_pkg::Q_W+1)'(inc);
		if (d.ovf) return neg ? sbc_pkg::T_MIN : sbc_pkg::T_MAX;
		if (!neg) return (mag > (sbc_pkg::Q_W+1)'(sbc_pkg::T_MAX)) ? sbc_pkg::T_MAX : 32'(mag);
		return (mag > (sbc_pkg::Q_W+1)'(64'd1 << 31)) ? sbc_pkg::T_MIN : 32'(-mag);
	endfunction

	logic               vld_s1;
	sbc_pkg::side_t     side_s1;
	logic signed [31:0] nx_s1, fx_s1, ny_s1, fy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side;
			nx_s1 <= side.dz_x ? sbc_pkg::T_MIN :
				fix(dres[sbc_pkg::DIV_NX], side.neg[sbc_pkg::DIV_NX], 1'b0);
			fx_s1 <= side.dz_x ? sbc_pkg::T_MAX :
				fix(dres[sbc_pkg::DIV_FX], side.neg[sbc_pkg::DIV_FX], 1'b1);
			ny_s1 <= side.dz_y ? sbc_pkg::T_MIN :
				fix(dres[sbc_pkg::DIV_NY], side.neg[sbc_pkg::DIV_NY], 1'b0);
			fy_s1 <= side.dz_y ? sbc_pkg::T_MAX :
				fix(dres[sbc_pkg::DIV_FY], side.neg[sbc_pkg::DIV_FY], 1'b1);
		end
	end

	logic hit_c, x_first;

	always_comb begin
		hit_c = side_s1.broad;
		if (fx_s1 <= 0 && fy_s1 <= 0) hit_c = 1'b0;
		if (nx_s1 >= sbc_pkg::T_ONE && ny_s1 >= sbc_pkg::T_ONE) hit_c = 1'b0;
		if (nx_s1 >= fy_s1 || ny_s1 >= fx_s1) hit_c = 1'b0;
		x_first = nx_s1 >= ny_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit <= hit_c;
			if (!hit_c) begin
				hit_time    <= '0;
				normal_face <= sbc_pkg::FACE_LEFT;
			end else if (x_first) begin
				hit_time    <= nx_s1;
				normal_face <= side_s1.px_neg ? sbc_pkg::FACE_RIGHT : sbc_pkg::FACE_LEFT;
			end else begin
				hit_time    <= ny_s1;
				normal_face <= side_s1.py_neg ? sbc_pkg::FACE_DOWN : sbc_pkg::FACE_UP;
			end
		end
	end

endmodule
`default_nettype wire

// ===== bench/swept_box_collision_check.sv =====
// Checker for the swept box collision block: watches both stream channels,
// predicts each result from the accepted input beat and compares in order.
// Depends on sbc_pkg for the face codes and time constants.
`default_nettype none
module swept_box_collision_check (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [319:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [39:0]  m_tdata,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]         face;
		logic signed [31:0] t;
		logic               hit;
	} contact_t;

	contact_t contacts_due[$];

	// Slab bound n * 2^F / d, rounded down or up, saturated to 32 bits.
	function automatic longint bound_time(longint n, longint d, bit up);
		longint s, q, r;
		s = n <<< sbc_pkg::FRAC_BITS;
		q = s / d;
		r = s % d;
		if (r != 0) begin
			if (((s < 0) != (d < 0)) && !up) q = q - 1;
			if (((s < 0) == (d < 0)) && up) q = q + 1;
		end
		if (q > longint'(sbc_pkg::T_MAX)) q = sbc_pkg::T_MAX;
		if (q < longint'(sbc_pkg::T_MIN)) q = sbc_pkg::T_MIN;
		return q;
	endfunction

	function automatic void slab_bounds(longint lo, longint hi, longint d,
			output longint nr, output longint fr);
		if (d == 0) begin
			nr = sbc_pkg::T_MIN;
			fr = sbc_pkg::T_MAX;
		end else if (d > 0) begin
			nr = bound_time(lo, d, 0);
			fr = bound_time(hi, d, 1);
		end else begin
			nr = bound_time(hi, d, 0);
			fr = bound_time(lo, d, 1);
		end
	endfunction

	function automatic contact_t sweep_contact(logic [319:0] d);
		longint ml, mt, mw, mh, px, py, tl, tt, tw, th;
		longint bl, br, bt, bb, nx, fx, ny, fy;
		contact_t c;
		ml = longint'($signed(d[31:0]));
		mt = longint'($signed(d[63:32]));
		mw = longint'({1'b0, d[94:64]});
		mh = longint'({1'b0, d[125:95]});
		px = longint'($signed(d[157:126]));
		py = longint'($signed(d[189:158]));
		tl = longint'($signed(d[221:190]));
		tt = longint'($signed(d[253:222]));
		tw = longint'({1'b0, d[284:254]});
		th = longint'({1'b0, d[315:285]});
		c = '0;
		bl = ml + (px < 0 ? px : 0);
		br = ml + mw + (px > 0 ? px : 0);
		bt = mt + (py < 0 ? py : 0);
		bb = mt + mh + (py > 0 ? py : 0);
		if ((bl > tl ? bl : tl) < (br < tl + tw ? br : tl + tw) &&
				(bt > tt ? bt : tt) < (bb < tt + th ? bb : tt + th)) begin
			slab_bounds(tl - ml - mw, tl + tw - ml, px, nx, fx);
			slab_bounds(tt - mt - mh, tt + th - mt, py, ny, fy);
			c.hit = !((fx <= 0 && fy <= 0) ||
				(nx >= sbc_pkg::T_ONE && ny >= sbc_pkg::T_ONE) ||
				nx >= fy || ny >= fx);
			if (c.hit) begin
				if (nx >= ny) begin
					c.t = 32'(nx);
					c.face = px < 0 ? sbc_pkg::FACE_RIGHT : sbc_pkg::FACE_LEFT;
				end else begin
					c.t = 32'(ny);
					c.face = py < 0 ? sbc_pkg::FACE_DOWN : sbc_pkg::FACE_UP;
				end
			end
		end
		return c;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		contact_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) contacts_due.push_back(sweep_contact(s_tdata));
			if (m_tvalid && m_tready) begin
				if (contacts_due.size() == 0) begin
					report("unexpected result beat", 0, 0);
				end else begin
					want = contacts_due.pop_front();
					if (m_tdata[0] !== want.hit) report("hit", m_tdata[0], want.hit);
					if (m_tdata[32:1] !== want.t)
						report("hit_time", $signed(m_tdata[32:1]), want.t);
					if (m_tdata[34:33] !== want.face)
						report("normal_face", m_tdata[34:33], want.face);
				end
			end
			pending = contacts_due.size();
		end
	end
endmodule
`default_nettype wire

// ===== bench/swept_box_collision_test.sv =====
// Top of the swept box collision testbench: clock, reset, directed and random
// input beats, random output stalls, watchdog and verdict.
// Depends on sbc_pkg, swept_box_collision and swept_box_collision_check.
`default_nettype none
module swept_box_collision_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic [319:0] s_tdata = '0;
	logic         m_tready = 0;
	wire          s_tready;
	wire          m_tvalid;
	wire  [39:0]  m_tdata;
	int           errors, pending;
	int           idle_cycles = 0;

	swept_box_collision uut (.*);
	swept_box_collision_check checker_i (.*);

	initial forever #2 clk = ~clk;

	// Gap lengths: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Random 32 bit value: corner values now and then, otherwise near zero or
	// wide, so both the overlap and the saturating cases turn up.
	function automatic logic [31:0] pick_s32(int span);
		case ($urandom_range(9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return '0;
			3, 4: return $urandom();
			default: return 32'($signed($urandom_range(2 * span)) - span);
		endcase
	endfunction

	function automatic logic [30:0] pick_u31(int span);
		case ($urandom_range(9))
			0: return 31'h7fffffff;
			1: return '0;
			2: return 31'($urandom());
			default: return 31'($urandom_range(span));
		endcase
	endfunction

	function automatic logic [319:0] pack_boxes(logic [31:0] ml, mt, logic [30:0] mw, mh,
			logic [31:0] px, py, tl, tt, logic [30:0] tw, th);
		return {4'b0, th, tw, tt, tl, py, px, mh, mw, mt, ml};
	endfunction

	// Holds one beat on the slave side until it is taken, after an optional gap.
	task automatic send_beat(logic [319:0] d);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	// Boxes placed near each other so that the slab logic is well exercised.
	function automatic logic [319:0] near_pair();
		int unit;
		logic [31:0] ml, mt;
		unit = 1 << $urandom_range(20, 12);
		ml = pick_s32(8 * unit);
		mt = pick_s32(8 * unit);
		return pack_boxes(ml, mt, 31'($urandom_range(4 * unit)), 31'($urandom_range(4 * unit)),
			$urandom_range(3) == 0 ? 32'd0 : 32'($signed($urandom_range(16 * unit)) - 8 * unit),
			$urandom_range(3) == 0 ? 32'd0 : 32'($signed($urandom_range(16 * unit)) - 8 * unit),
			ml + 32'($signed($urandom_range(12 * unit)) - 6 * unit),
			mt + 32'($signed($urandom_range(12 * unit)) - 6 * unit),
			31'($urandom_range(4 * unit)), 31'($urandom_range(4 * unit)));
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: head-on hits from each side, resting overlap, empty boxes,
		// near misses, tunneling sweeps and the extremes of every field.
		send_beat(pack_boxes(0, 0, 31'h10000, 31'h10000, 32'h40000, 0,
			32'h20000, 0, 31'h10000, 31'h10000));
		send_beat(pack_boxes(32'h40000, 0, 31'h10000, 31'h10000, 32'hfffc0000, 0,
			32'h20000, 0, 31'h10000, 31'h10000));
		send_beat(pack_boxes(0, 0, 31'h10000, 31'h10000, 0, 32'h40000,
			0, 32'h20000, 31'h10000, 31'h10000));
		send_beat(pack_boxes(0, 32'h40000, 31'h10000, 31'h10000, 0, 32'hfffc0000,
			0, 32'h20000, 31'h10000, 31'h10000));
		send_beat(pack_boxes(0, 0, 31'h20000, 31'h20000, 0, 0,
			32'h10000, 32'h10000, 31'h20000, 31'h20000));
		send_beat(pack_boxes(0, 0, 31'd0, 31'h10000, 32'h40000, 0, 32'h20000, 0,
			31'h10000, 31'h10000));
		send_beat(pack_boxes(0, 0, 31'h10000, 31'h10000, 32'h40000, 0, 32'h20000, 0,
			31'd0, 31'd0));
		send_beat(pack_boxes(0, 0, 31'h10000, 31'h10000, 32'h40000, 32'h40000,
			32'h20000, 0, 31'h10000, 31'h10000));
		send_beat(pack_boxes(0, 0, 31'h10000, 31'h10000, 32'h10000, 0,
			32'h20000, 0, 31'h10000, 31'h10000));
		send_beat(pack_boxes(0, 0, 31'h10, 31'h10, 32'h7fffffff, 32'h30,
			32'h1000, 0, 31'h10, 31'h10));
		send_beat(pack_boxes(32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff));
		send_beat(pack_boxes(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff));
		send_beat(pack_boxes(32'h80000000, 0, 31'h7fffffff, 31'h7fffffff, 32'h80000000, 1,
			32'h80000000, 0, 31'h7fffffff, 31'h7fffffff));
		send_beat(pack_boxes(0, 0, 31'd1, 31'd1, 1, 32'hffffffff, 0, 0, 31'd1, 31'd1));
		send_beat(pack_boxes(32'hffffffff, 32'hffffffff, 31'h55555555, 31'h2aaaaaaa,
			32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa, 31'h55555555));
		send_beat('0);
		// Random: mostly boxes close enough to interact, the rest wide noise.
		repeat (400) begin
			if ($urandom_range(9) < 8) send_beat(near_pair());
			else send_beat(pack_boxes(pick_s32(1 << 30), pick_s32(1 << 30), pick_u31(1 << 30),
				pick_u31(1 << 30), pick_s32(1 << 30), pick_s32(1 << 30), pick_s32(1 << 30),
				pick_s32(1 << 30), pick_u31(1 << 30), pick_u31(1 << 30)));
		end
		s_tvalid <= 0;
		// Wait so the checker has queued the last beat before draining.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	// Receiver stalls, with the same mix of short and long gaps.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			m_tready <= 1;
			repeat ($urandom_range(20, 1)) @(posedge clk);
			g = gap_len();
			if (g != 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run after too many cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end
endmodule
`default_nettype wire
